### hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion macros used by the checker bdq_chk.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, off while reset is low
`define BDQ_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked assertion, always on
`define BDQ_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### hdl/bdq_pkg.sv
// ----------------------------------------------------------------------------
// bdq_pkg
// Types and constants of the bounded deque with match operations.
// ----------------------------------------------------------------------------
`default_nettype none

package bdq_pkg;

    localparam int DEPTH      = 64;
    localparam int ITEM_WIDTH = 32;
    localparam int AW         = $clog2(DEPTH);
    localparam int CW         = $clog2(DEPTH + 1);
    localparam int DATA_W     = 32;
    localparam int REQ_W      = 3;
    localparam int STAT_W     = 2;

    typedef enum logic [REQ_W-1:0] {
        REQ_PUSH_FRONT = 3'd0,
        REQ_PUSH_BACK  = 3'd1,
        REQ_POP_FRONT  = 3'd2,
        REQ_POP_BACK   = 3'd3,
        REQ_COUNT      = 3'd4,
        REQ_REMOVE     = 3'd5
    } t_req;

    typedef enum logic [STAT_W-1:0] {
        STAT_OK    = 2'd0,
        STAT_FULL  = 2'd1,
        STAT_EMPTY = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_POP_WAIT,
        ST_WALK,
        ST_RD_FRONT,
        ST_RD_BACK,
        ST_DONE
    } t_state;

endpackage

`default_nettype wire

### hdl/bounded_deque_with_match_ops_unit.sv
// ----------------------------------------------------------------------------
// bounded_deque_with_match_ops_unit
// Circular deque in one synchronous RAM with push, pop, count and remove.
// ----------------------------------------------------------------------------
// channel   | handshake          | payload
// request   | start / busy       | i_req_type, i_item_value
// result    | o_valid (1 cycle)  | o_status .. o_is_empty
//
// Push runs EXEC, RD_FRONT, RD_BACK and DONE; pop adds POP_WAIT after EXEC;
// count and remove walk the stored entries in WALK after EXEC.
// The count and remove walk reads one entry per cycle from the single RAM
// read port; remove writes kept entries back through the write port.
// Each result closes with two RAM reads for the front and back entries, skipped on an empty store.
// Reset clears the pointers and the count; the RAM needs no clearing pass.
// The result beat cannot be stalled; busy drops in the cycle it shows.
// ----------------------------------------------------------------------------
`default_nettype none

module bounded_deque_with_match_ops_unit (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                start,
    output logic                                     busy,
    input  wire logic [bdq_pkg::REQ_W-1:0]           i_req_type,
    input  wire logic signed [bdq_pkg::DATA_W-1:0]   i_item_value,
    output logic                                     o_valid,
    output logic [bdq_pkg::STAT_W-1:0]               o_status,
    output logic signed [bdq_pkg::DATA_W-1:0]        o_popped_value,
    output logic [bdq_pkg::CW-1:0]                   o_match_count,
    output logic [bdq_pkg::CW-1:0]                   o_entry_total,
    output logic signed [bdq_pkg::DATA_W-1:0]        o_front_value,
    output logic signed [bdq_pkg::DATA_W-1:0]        o_back_value,
    output logic                                     o_is_empty
);

    localparam int DEPTH = bdq_pkg::DEPTH;
    localparam int IW    = bdq_pkg::ITEM_WIDTH;
    localparam int AW    = bdq_pkg::AW;
    localparam int CW    = bdq_pkg::CW;
    localparam int DW    = bdq_pkg::DATA_W;

    function automatic logic [AW-1:0] wrap_add(input logic [AW-1:0] base,
                                               input logic [CW-1:0] ofs);
        logic [CW:0] sum;
        sum = (CW+1)'(base) + (CW+1)'(ofs);
        if (sum >= (CW+1)'(DEPTH)) begin
            sum = sum - (CW+1)'(DEPTH);
        end
        return sum[AW-1:0];
    endfunction

    logic [IW-1:0]     r_mem [DEPTH];
    logic [IW-1:0]     r_rdata;

    bdq_pkg::t_state   r_state,     n_state;
    bdq_pkg::t_req     r_req,       n_req;
    logic [IW-1:0]     r_item,      n_item;
    logic [AW-1:0]     r_front_idx, n_front_idx;
    logic [CW-1:0]     r_count,     n_count;
    logic [CW-1:0]     r_idx,       n_idx;
    logic              r_rvld,      n_rvld;
    logic [CW-1:0]     r_kept,      n_kept;
    logic [CW-1:0]     r_match,     n_match;
    bdq_pkg::t_status  r_status,    n_status;
    logic [IW-1:0]     r_popped,    n_popped;
    logic [IW-1:0]     r_front_val, n_front_val;
    logic              r_valid,     n_valid;
    logic [DW-1:0]     r_o_front,   n_o_front;
    logic [DW-1:0]     r_o_back,    n_o_back;

    logic              mem_we;
    logic [AW-1:0]     mem_waddr;
    logic [IW-1:0]     mem_wdata;
    logic              mem_re;
    logic [AW-1:0]     mem_raddr;
    logic              issue;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            r_rdata <= r_mem[mem_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= bdq_pkg::ST_IDLE;
            r_front_idx <= '0;
            r_count     <= '0;
            r_rvld      <= 1'b0;
            r_valid     <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_front_idx <= n_front_idx;
            r_count     <= n_count;
            r_rvld      <= n_rvld;
            r_valid     <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_req       <= n_req;
        r_item      <= n_item;
        r_idx       <= n_idx;
        r_kept      <= n_kept;
        r_match     <= n_match;
        r_status    <= n_status;
        r_popped    <= n_popped;
        r_front_val <= n_front_val;
        r_o_front   <= n_o_front;
        r_o_back    <= n_o_back;
    end

    always_comb begin
        n_state     = r_state;
        n_req       = r_req;
        n_item      = r_item;
        n_front_idx = r_front_idx;
        n_count     = r_count;
        n_idx       = r_idx;
        n_rvld      = 1'b0;
        n_kept      = r_kept;
        n_match     = r_match;
        n_status    = r_status;
        n_popped    = r_popped;
        n_front_val = r_front_val;
        n_valid     = 1'b0;
        n_o_front   = r_o_front;
        n_o_back    = r_o_back;
        mem_we      = 1'b0;
        mem_waddr   = r_front_idx;
        mem_wdata   = r_item;
        mem_re      = 1'b0;
        mem_raddr   = r_front_idx;
        issue       = 1'b0;

        unique case (r_state)
            bdq_pkg::ST_IDLE: begin
                if (start) begin
                    n_req    = bdq_pkg::t_req'(i_req_type);
                    n_item   = i_item_value[IW-1:0];
                    n_idx    = '0;
                    n_kept   = '0;
                    n_match  = '0;
                    n_status = bdq_pkg::STAT_OK;
                    n_popped = '0;
                    n_state  = bdq_pkg::ST_EXEC;
                end
            end
            bdq_pkg::ST_EXEC: begin
                n_state = bdq_pkg::ST_RD_FRONT;
                case (r_req)
                    bdq_pkg::REQ_PUSH_FRONT: begin
                        if (r_count == CW'(DEPTH)) begin
                            n_status = bdq_pkg::STAT_FULL;
                        end else begin
                            n_front_idx = (r_front_idx == '0) ? AW'(DEPTH - 1)
                                                              : r_front_idx - AW'(1);
                            mem_we      = 1'b1;
                            mem_waddr   = n_front_idx;
                            n_count     = r_count + CW'(1);
                        end
                    end
                    bdq_pkg::REQ_PUSH_BACK: begin
                        if (r_count == CW'(DEPTH)) begin
                            n_status = bdq_pkg::STAT_FULL;
                        end else begin
                            mem_we    = 1'b1;
                            mem_waddr = wrap_add(r_front_idx, r_count);
                            n_count   = r_count + CW'(1);
                        end
                    end
                    bdq_pkg::REQ_POP_FRONT, bdq_pkg::REQ_POP_BACK: begin
                        if (r_count == '0) begin
                            n_status = bdq_pkg::STAT_EMPTY;
                        end else begin
                            mem_re    = 1'b1;
                            mem_raddr = (r_req == bdq_pkg::REQ_POP_FRONT) ? r_front_idx
                                      : wrap_add(r_front_idx, r_count - CW'(1));
                            n_state   = bdq_pkg::ST_POP_WAIT;
                        end
                    end
                    bdq_pkg::REQ_COUNT, bdq_pkg::REQ_REMOVE: begin
                        n_state = bdq_pkg::ST_WALK;
                    end
                    default: begin
                        n_state = bdq_pkg::ST_RD_FRONT;
                    end
                endcase
            end
            bdq_pkg::ST_POP_WAIT: begin
                n_popped = r_rdata;
                n_count  = r_count - CW'(1);
                if (r_req == bdq_pkg::REQ_POP_FRONT) begin
                    n_front_idx = (r_front_idx == AW'(DEPTH - 1)) ? '0
                                                                  : r_front_idx + AW'(1);
                end
                n_state = bdq_pkg::ST_RD_FRONT;
            end
            bdq_pkg::ST_WALK: begin
                issue     = (r_idx < r_count);
                mem_re    = issue;
                mem_raddr = wrap_add(r_front_idx, r_idx);
                n_rvld    = issue;
                if (issue) begin
                    n_idx = r_idx + CW'(1);
                end
                if (r_rvld) begin
                    if (r_rdata == r_item) begin
                        n_match = r_match + CW'(1);
                    end else if (r_req == bdq_pkg::REQ_REMOVE) begin
                        mem_we    = 1'b1;
                        mem_waddr = wrap_add(r_front_idx, r_kept);
                        mem_wdata = r_rdata;
                        n_kept    = r_kept + CW'(1);
                    end
                end
                if (!issue && !r_rvld) begin
                    if (r_req == bdq_pkg::REQ_REMOVE) begin
                        n_count = r_kept;
                    end
                    n_state = bdq_pkg::ST_RD_FRONT;
                end
            end
            bdq_pkg::ST_RD_FRONT: begin
                mem_re    = (r_count != '0);
                mem_raddr = r_front_idx;
                n_state   = bdq_pkg::ST_RD_BACK;
            end
            bdq_pkg::ST_RD_BACK: begin
                mem_re      = (r_count != '0);
                mem_raddr   = wrap_add(r_front_idx, r_count - CW'(1));
                n_front_val = r_rdata;
                n_state     = bdq_pkg::ST_DONE;
            end
            bdq_pkg::ST_DONE: begin
                n_o_front = (r_count != '0) ? DW'(r_front_val) : '0;
                n_o_back  = (r_count != '0) ? DW'(r_rdata) : '0;
                n_valid   = 1'b1;
                n_state   = bdq_pkg::ST_IDLE;
            end
            default: begin
                n_state = bdq_pkg::ST_IDLE;
            end
        endcase
    end

    logic [DW-1:0] popped_ext;
    assign popped_ext = DW'(r_popped);

    assign busy           = (r_state != bdq_pkg::ST_IDLE);
    assign o_valid        = r_valid;
    assign o_status       = r_status;
    assign o_popped_value = popped_ext;
    assign o_match_count  = r_match;
    assign o_entry_total  = r_count;
    assign o_front_value  = r_o_front;
    assign o_back_value   = r_o_back;
    assign o_is_empty     = (r_count == '0);

endmodule

`default_nettype wire

### hdl/bdq_chk.sv
// ----------------------------------------------------------------------------
// bdq_chk
// Port-level checks on the deque unit, bound into every instance of it.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module bdq_chk (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               start,
    input  wire logic                               busy,
    input  wire logic                               o_valid,
    input  wire logic [bdq_pkg::STAT_W-1:0]         o_status,
    input  wire logic [bdq_pkg::CW-1:0]             o_entry_total,
    input  wire logic signed [bdq_pkg::DATA_W-1:0]  o_front_value,
    input  wire logic signed [bdq_pkg::DATA_W-1:0]  o_back_value,
    input  wire logic                               o_is_empty
);

    `BDQ_ASSERT(a_accept_busy, i_clk, i_rst_n, (start && !busy) |=> busy, "busy not raised")
    `BDQ_ASSERT(a_beat_single, i_clk, i_rst_n, o_valid |=> !o_valid, "result beat repeated")
    `BDQ_ASSERT(a_beat_idle, i_clk, i_rst_n, o_valid |-> !busy, "result beat while busy")
    `BDQ_ASSERT(a_empty_zero, i_clk, i_rst_n, (o_valid && o_is_empty) |-> (o_entry_total == '0 && o_front_value == '0 && o_back_value == '0), "empty result not zero")
    `BDQ_ASSERT(a_full_total, i_clk, i_rst_n, (o_valid && o_status == bdq_pkg::STAT_FULL) |-> (o_entry_total == bdq_pkg::CW'(bdq_pkg::DEPTH)), "full refusal below depth")

endmodule

bind bounded_deque_with_match_ops_unit bdq_chk u_bdq_chk (.*);

`default_nettype wire
